// ===== hw/rtl/smes_pkg.sv =====
// Shared types and constants for the sparse matrix entry store.
// Used by smes_ctrl, smes_datapath and sparse_matrix_entry_store_top; no dependencies.
`default_nettype none

package smes_pkg;

	// Field widths
	localparam int SIZE_W = 9;
	localparam int IDX_W  = 8;
	localparam int VAL_W  = 64;
	localparam int STS_W  = 2;

	// matrix_size after reset
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// Operation codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	// One off-diagonal table entry
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} entry_t;

	// Source of the result word
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_RANGE,
		RES_FULL,
		RES_DIAG,
		RES_ENTRY
	} res_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     diag_wr;
		logic     scan_init;
		logic     scan_en;
		logic     entry_upd;
		logic     entry_app;
		logic     res_ld;
		res_sel_t res_sel;
		logic     out_ld;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic range_err;
		logic is_diag;
		logic is_write;
		logic hit;
		logic miss;
		logic full;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smes_ctrl.sv =====
// Transaction sequencer for the sparse matrix entry store.
// Depends on smes_pkg for the command and status structs.
`default_nettype none

module smes_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire smes_pkg::sts_t sts,
	output smes_pkg::cmd_t     cmd
);
	import smes_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIAG,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	// One transaction in flight at a time
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_sel = RES_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.range_err) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_RANGE;
					state_d     = ST_OUT;
				end else if (sts.is_diag) begin
					if (sts.is_write) begin
						cmd.diag_wr = 1'b1;
						cmd.res_ld  = 1'b1;
						state_d     = ST_OUT;
					end else begin
						state_d = ST_DIAG;
					end
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_DIAG: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = RES_DIAG;
				state_d     = ST_OUT;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.hit) begin
					cmd.res_ld = 1'b1;
					if (sts.is_write) begin
						cmd.entry_upd = 1'b1;
					end else begin
						cmd.res_sel = RES_ENTRY;
					end
					state_d = ST_OUT;
				end else if (sts.miss) begin
					cmd.res_ld = 1'b1;
					if (sts.is_write) begin
						if (sts.full) begin
							cmd.res_sel = RES_FULL;
						end else begin
							cmd.entry_app = 1'b1;
						end
					end
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Diagonal writes only for in-range diagonal transactions
	a_diag_wr_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.diag_wr |-> (sts.is_diag && !sts.range_err && sts.is_write))
		else $error("diagonal write outside a valid diagonal write");

endmodule

`default_nettype wire

// ===== hw/rtl/smes_datapath.sv =====
// Storage and result path: size register, diagonal store, entry table and scan, output register.
// Depends on smes_pkg; driven by smes_ctrl through cmd_t / sts_t.
`default_nettype none

module smes_datapath #(
	parameter int MAX_DIM     = 256,
	parameter int MAX_ENTRIES = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [smes_pkg::SIZE_W-1:0]     cfg_wr_data,
	input  wire logic                            operation,
	input  wire logic [smes_pkg::IDX_W-1:0]      row_index,
	input  wire logic [smes_pkg::IDX_W-1:0]      col_index,
	input  wire logic [smes_pkg::VAL_W-1:0]      write_value,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [smes_pkg::VAL_W-1:0]           read_value,
	output logic [smes_pkg::STS_W-1:0]           status,
	input  wire smes_pkg::cmd_t                  cmd,
	output smes_pkg::sts_t                       sts
);
	import smes_pkg::*;

	// Diagonal store covers only rows reachable through an 8-bit index
	localparam int DIAG_DEPTH = (MAX_DIM < (1 << IDX_W)) ? MAX_DIM : (1 << IDX_W);
	localparam int DAW        = $clog2(DIAG_DEPTH);
	localparam int DIM_CAP    = (MAX_DIM < (1 << SIZE_W)) ? MAX_DIM : ((1 << SIZE_W) - 1);
	localparam logic [SIZE_W-1:0] DIM_CAP_V = DIM_CAP[SIZE_W-1:0];
	// Entry table addressing and fill count
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] limit;

	logic              op_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [VAL_W-1:0]  wv_q;

	logic [VAL_W-1:0]      diag_mem [DIAG_DEPTH];
	logic [DIAG_DEPTH-1:0] diag_vld_q;
	logic [VAL_W-1:0]      diag_rd_q;
	logic                  diag_rd_vld_q;
	logic [DAW-1:0]        diag_addr;

	entry_t            ent_mem [MAX_ENTRIES];
	entry_t            ent_rd_q;
	entry_t            ent_wr_data;
	logic [EAW-1:0]    ent_wr_addr;
	logic              ent_wr_en;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     scan_q;
	logic              cmp_vld_s1;
	logic [EAW-1:0]    idx_s1;
	logic              issue;
	logic              hit;
	logic              miss;

	logic [VAL_W-1:0]  res_val_d;
	logic [STS_W-1:0]  res_sts_d;
	logic [VAL_W-1:0]  res_val_q;
	logic [STS_W-1:0]  res_sts_q;

	logic              out_valid_q;
	logic [VAL_W-1:0]  read_value_q;
	logic [STS_W-1:0]  status_q;

	// Matrix size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	assign limit = (size_q > DIM_CAP_V) ? DIM_CAP_V : size_q;

	// Captured transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			row_q <= row_index;
			col_q <= col_index;
			wv_q  <= write_value;
		end
	end

	// Diagonal store: data in a memory, written flags in flops
	assign diag_addr = row_q[DAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_vld_q <= '0;
		end else if (cmd.diag_wr) begin
			diag_vld_q[diag_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diag_wr) begin
			diag_mem[diag_addr] <= wv_q;
		end
		diag_rd_q     <= diag_mem[diag_addr];
		diag_rd_vld_q <= diag_vld_q[diag_addr];
	end

	// Scan: issue one table read per cycle, compare it the cycle after
	assign issue = (scan_q < cnt_q);
	assign hit   = cmp_vld_s1 && (ent_rd_q.row == row_q) && (ent_rd_q.col == col_q);
	assign miss  = !cmp_vld_s1 && !issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (cmd.scan_en) begin
			cmp_vld_s1 <= issue && !hit;
			if (issue) begin
				scan_q <= scan_q + CW'(1);
			end
		end
	end

	// Entry table write port: overwrite at the hit, or append at the fill count
	assign ent_wr_en   = cmd.entry_upd || cmd.entry_app;
	assign ent_wr_addr = cmd.entry_upd ? idx_s1 : cnt_q[EAW-1:0];
	assign ent_wr_data = '{row: row_q, col: col_q, value: wv_q};

	always_ff @(posedge clk) begin
		if (ent_wr_en) begin
			ent_mem[ent_wr_addr] <= ent_wr_data;
		end
		ent_rd_q <= ent_mem[scan_q[EAW-1:0]];
		idx_s1   <= scan_q[EAW-1:0];
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.entry_app) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Result select
	always_comb begin
		res_val_d = '0;
		res_sts_d = STS_OK;
		unique case (cmd.res_sel)
			RES_ZERO:  res_sts_d = STS_OK;
			RES_RANGE: res_sts_d = STS_RANGE;
			RES_FULL:  res_sts_d = STS_FULL;
			RES_DIAG:  res_val_d = diag_rd_vld_q ? diag_rd_q : '0;
			RES_ENTRY: res_val_d = ent_rd_q.value;
			default:   res_sts_d = STS_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_val_q <= res_val_d;
			res_sts_q <= res_sts_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			read_value_q <= res_val_q;
			status_q     <= res_sts_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	// Status to controller
	assign sts.range_err = ({1'b0, row_q} >= limit) || ({1'b0, col_q} >= limit);
	assign sts.is_diag   = (row_q == col_q);
	assign sts.is_write  = (op_q == OP_WRITE);
	assign sts.hit       = hit;
	assign sts.miss      = miss;
	assign sts.full      = (cnt_q == CNT_MAX);
	assign sts.out_free  = !out_valid_q || !out_stall;

	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit && miss))
		else $error("scan reports hit and miss together");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above table depth");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.entry_app |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("append did not advance the entry count");

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_matrix_entry_store_top.sv =====
// Sparse matrix entry store, top level: joins the sequencer and the datapath.
// Depends on smes_pkg, smes_ctrl and smes_datapath.
//
// Stores a square sparse matrix: diagonal words in a dense store, off-diagonal words in a
// table of up to MAX_ENTRIES (row, column, value) entries filled in write order. Each input
// transaction is one read or write and gives exactly one result transaction. Transactions are
// handled one at a time; a finished result waits in the output register while the next
// transaction is taken. Off-diagonal transactions scan the entry table, a memory with one read
// port and one write port, one entry per cycle until the match or the end of the filled part.
// No clearing pass is needed after reset.
`default_nettype none

module sparse_matrix_entry_store_top #(
	parameter int MAX_DIM     = 256,
	parameter int MAX_ENTRIES = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [smes_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         operation,
	input  wire logic [smes_pkg::IDX_W-1:0]   row_index,
	input  wire logic [smes_pkg::IDX_W-1:0]   col_index,
	input  wire logic [smes_pkg::VAL_W-1:0]   write_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [smes_pkg::VAL_W-1:0]        read_value,
	output logic [smes_pkg::STS_W-1:0]        status
);
	import smes_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	smes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and result path
	smes_datapath #(
		.MAX_DIM     (MAX_DIM),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operation   (operation),
		.row_index   (row_index),
		.col_index   (col_index),
		.write_value (write_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.read_value  (read_value),
		.status      (status),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire
